// ===== rtl/tswl_pkg.sv =====
// Shared types and constants for the timeline semaphore waiter list.
// Used by timeline_semaphore_waiter_list and its testbench; no dependencies.
`default_nettype none
package tswl_pkg;
   localparam int WAITER_SLOTS = 16;
   localparam int TARGET_BITS  = 8;
   localparam int IDX_BITS     = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
   localparam int CNT_BITS     = $clog2(WAITER_SLOTS + 1);

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_WAKE   = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   localparam logic [2:0] ST_QUEUED    = 3'd0;
   localparam logic [2:0] ST_SATISFIED = 3'd1;
   localparam logic [2:0] ST_LOWERED   = 3'd2;
   localparam logic [2:0] ST_KEPT      = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [TARGET_BITS-1:0] target;
      logic [63:0]            minimum;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);
endpackage
`default_nettype wire

// ===== rtl/tswl_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
`default_nettype none
module tswl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [ABITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [ABITS-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/timeline_semaphore_waiter_list.sv =====
// Timeline semaphore with a sorted waiter list held in one RAM (tswl_ram).
// Depends on tswl_pkg. A wait scans the list and may shift entries up; a signal
// inspects entries from the head and then slides the kept entries down.
// One transaction at a time: the list scan and shift share the single RAM
// read and write port. Reset clears the value, the count and self target.
`default_nettype none
module timeline_semaphore_waiter_list (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // target[7:0], value[71:8]
   input  wire logic [0:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [79:0] rsp_tdata,   // status[2:0], wake_target[10:3],
                                         // seen_value[74:11], self_woke[75]
   output logic      [1:0]  rsp_tuser,   // kind
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // self_target
);
   localparam int IB = tswl_pkg::IDX_BITS;
   localparam int CB = tswl_pkg::CNT_BITS;
   localparam int TB = tswl_pkg::TARGET_BITS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_WRD  = 4'd1;  // wait scan: issue read
   localparam logic [3:0] S_WEV  = 4'd2;  // wait scan: evaluate
   localparam logic [3:0] S_SHRD = 4'd3;  // shift up: read
   localparam logic [3:0] S_SHWR = 4'd4;  // shift up: write
   localparam logic [3:0] S_INS  = 4'd5;
   localparam logic [3:0] S_WOUT = 4'd6;
   localparam logic [3:0] S_PRD  = 4'd7;  // pop scan: read
   localparam logic [3:0] S_PEV  = 4'd8;  // pop scan: evaluate
   localparam logic [3:0] S_CRD  = 4'd9;  // compact: read
   localparam logic [3:0] S_CWR  = 4'd10; // compact: write
   localparam logic [3:0] S_DONE = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic [CB-1:0] le_ff, le_in;
   logic [CB-1:0] fidx_ff, fidx_in;
   logic [CB-1:0] popped_ff, popped_in;
   logic          found_ff, found_in;
   logic [63:0]   fmin_ff, fmin_in;
   logic [TB-1:0] tgt_ff, tgt_in;
   logic [63:0]   val_ff, val_in;
   logic [2:0]    status_ff, status_in;
   logic          selfw_ff, selfw_in;
   logic [63:0]   cur_ff, cur_in;
   logic [7:0]    self_ff, self_in;

   logic          out_v_ff, out_v_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic [2:0]    out_stat_ff, out_stat_in;
   logic [7:0]    out_tgt_ff, out_tgt_in;
   logic [63:0]   out_seen_ff, out_seen_in;
   logic          out_self_ff, out_self_in;

   logic                    ram_we, ram_re;
   logic [IB-1:0]           ram_waddr, ram_raddr;
   tswl_pkg::entry_type     ram_wdata, ram_rdata;
   logic [tswl_pkg::ENTRY_BITS-1:0] ram_rbits;

   logic          out_free;
   logic [CB:0]   src_idx;
   logic [CB-1:0] idx_dec;
   logic [15:0]   tgt_wide;
   logic [TB-1:0] me;

   tswl_ram #(
      .WIDTH(tswl_pkg::ENTRY_BITS),
      .DEPTH(tswl_pkg::WAITER_SLOTS)
   ) u_list (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rbits)
   );
   assign ram_rdata = tswl_pkg::entry_type'(ram_rbits);

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_v_ff && (out_kind_ff != tswl_pkg::KIND_WAKE);
   assign rsp_tdata  = {4'd0, out_self_ff, out_seen_ff, out_tgt_ff, out_stat_ff};

   // Result register may take a new result when empty or draining this cycle.
   assign out_free = !out_v_ff || rsp_tready;
   assign src_idx  = {1'b0, idx_ff} + {1'b0, popped_ff};
   assign idx_dec  = idx_ff - CB'(1);
   assign tgt_wide = 16'(ram_rdata.target);
   assign me       = TB'(self_ff);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      le_in       = le_ff;
      fidx_in     = fidx_ff;
      popped_in   = popped_ff;
      found_in    = found_ff;
      fmin_in     = fmin_ff;
      tgt_in      = tgt_ff;
      val_in      = val_ff;
      status_in   = status_ff;
      selfw_in    = selfw_ff;
      cur_in      = cur_ff;
      self_in     = self_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_kind_in = out_kind_ff;
      out_stat_in = out_stat_ff;
      out_tgt_in  = out_tgt_ff;
      out_seen_in = out_seen_ff;
      out_self_in = out_self_ff;
      ram_we      = 1'b0;
      ram_waddr   = idx_ff[IB-1:0];
      ram_wdata   = ram_rdata;
      ram_re      = 1'b0;
      ram_raddr   = idx_ff[IB-1:0];

      if (csr_valid) begin
         self_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               tgt_in   = TB'(req_tdata[7:0]);
               val_in   = req_tdata[71:8];
               idx_in   = '0;
               le_in    = '0;
               found_in = 1'b0;
               selfw_in = 1'b0;
               if (req_tuser[0]) begin
                  // Signal: take the new value now, then pop from the head.
                  cur_in   = req_tdata[71:8];
                  state_in = S_PRD;
               end else if (cur_ff >= req_tdata[71:8]) begin
                  status_in = tswl_pkg::ST_SATISFIED;
                  state_in  = S_WOUT;
               end else begin
                  state_in = S_WRD;
               end
            end
         end
         S_WRD: begin
            if (idx_ff == cnt_ff) begin
               // Scan finished: decide where the waiter goes.
               if (found_ff) begin
                  if (val_ff < fmin_ff) begin
                     status_in = tswl_pkg::ST_LOWERED;
                     idx_in    = fidx_ff;
                     state_in  = S_SHRD;
                  end else begin
                     status_in = tswl_pkg::ST_KEPT;
                     state_in  = S_WOUT;
                  end
               end else if (cnt_ff == CB'(tswl_pkg::WAITER_SLOTS)) begin
                  status_in = tswl_pkg::ST_FULL;
                  state_in  = S_WOUT;
               end else begin
                  status_in = tswl_pkg::ST_QUEUED;
                  cnt_in    = cnt_ff + CB'(1);
                  state_in  = S_SHRD;
               end
            end else begin
               ram_re   = 1'b1;
               state_in = S_WEV;
            end
         end
         S_WEV: begin
            if (!found_ff && ram_rdata.target == tgt_ff) begin
               found_in = 1'b1;
               fidx_in  = idx_ff;
               fmin_in  = ram_rdata.minimum;
            end
            if (ram_rdata.minimum <= val_ff) begin
               le_in = le_ff + CB'(1);
            end
            idx_in   = idx_ff + CB'(1);
            state_in = S_WRD;
         end
         S_SHRD: begin
            // Move entries in [le, idx) up by one, top first.
            if (idx_ff == le_ff) begin
               state_in = S_INS;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_dec[IB-1:0];
               state_in  = S_SHWR;
            end
         end
         S_SHWR: begin
            ram_we   = 1'b1;
            idx_in   = idx_dec;
            state_in = S_SHRD;
         end
         S_INS: begin
            ram_we            = 1'b1;
            ram_waddr         = le_ff[IB-1:0];
            ram_wdata.target  = tgt_ff;
            ram_wdata.minimum = val_ff;
            state_in          = S_WOUT;
         end
         S_WOUT: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_kind_in = tswl_pkg::KIND_STATUS;
               out_stat_in = status_ff;
               out_tgt_in  = 8'(tgt_ff);
               out_seen_in = cur_ff;
               out_self_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         S_PRD: begin
            if (idx_ff == cnt_ff) begin
               popped_in = idx_ff;
               idx_in    = '0;
               state_in  = S_CRD;
            end else begin
               ram_re   = 1'b1;
               state_in = S_PEV;
            end
         end
         S_PEV: begin
            if (ram_rdata.minimum > cur_ff) begin
               popped_in = idx_ff;
               idx_in    = '0;
               state_in  = S_CRD;
            end else if (ram_rdata.target == me) begin
               selfw_in = 1'b1;
               idx_in   = idx_ff + CB'(1);
               state_in = S_PRD;
            end else if (out_free) begin
               out_v_in    = 1'b1;
               out_kind_in = tswl_pkg::KIND_WAKE;
               out_stat_in = tswl_pkg::ST_QUEUED;
               out_tgt_in  = tgt_wide[7:0];
               out_seen_in = cur_ff;
               out_self_in = 1'b0;
               idx_in      = idx_ff + CB'(1);
               state_in    = S_PRD;
            end
         end
         S_CRD: begin
            // Slide the survivors down over the popped head.
            if (popped_ff == '0 || src_idx == {1'b0, cnt_ff}) begin
               cnt_in   = cnt_ff - popped_ff;
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = src_idx[IB-1:0];
               state_in  = S_CWR;
            end
         end
         S_CWR: begin
            ram_we   = 1'b1;
            idx_in   = idx_ff + CB'(1);
            state_in = S_CRD;
         end
         S_DONE: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_kind_in = tswl_pkg::KIND_DONE;
               out_stat_in = tswl_pkg::ST_QUEUED;
               out_tgt_in  = 8'd0;
               out_seen_in = cur_ff;
               out_self_in = selfw_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         self_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
         self_ff  <= self_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      le_ff       <= le_in;
      fidx_ff     <= fidx_in;
      popped_ff   <= popped_in;
      found_ff    <= found_in;
      fmin_ff     <= fmin_in;
      tgt_ff      <= tgt_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      selfw_ff    <= selfw_in;
      out_kind_ff <= out_kind_in;
      out_stat_ff <= out_stat_in;
      out_tgt_ff  <= out_tgt_in;
      out_seen_ff <= out_seen_in;
      out_self_ff <= out_self_in;
   end
endmodule
`default_nettype wire

// ===== bench/tb_timeline_semaphore_waiter_list.sv =====
// Self-checking testbench for timeline_semaphore_waiter_list: directed table, then random traffic.
// Depends on tswl_pkg and the block's RTL; keeps its own model of the semaphore and waiter list.
`default_nettype none
module tb_timeline_semaphore_waiter_list;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic FUNC_WAIT   = 1'b0;
   localparam logic FUNC_SIGNAL = 1'b1;
   localparam int   CYCLE_LIMIT = 600000;
   localparam logic [63:0] VALUE_MAX = '1;

   // one result of the block, unpacked
   typedef struct {
      logic [1:0]                       kind;
      logic [2:0]                       status;
      logic [tswl_pkg::TARGET_BITS-1:0] tgt;
      logic [63:0]                      seen;
      logic                             selfw;
      logic                             last;
   } sem_result_type;

   // one row of the directed table; typed rows carry the status read off by hand
   typedef struct {
      logic                             func;
      logic [tswl_pkg::TARGET_BITS-1:0] tgt;
      logic [63:0]                      val;
      logic                             typed;
      logic [2:0]                       status;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [71:0]       req_tdata;   // target[7:0], value[71:8]
   logic [0:0]        req_tuser;   // func
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [79:0]       rsp_tdata;   // status[2:0], wake_target[10:3], seen_value[74:11],
                                   // self_woke[75]
   logic [1:0]        rsp_tuser;   // kind
   logic              rsp_tlast;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_data;    // self_target

   // model state
   logic [tswl_pkg::TARGET_BITS-1:0] list_tgt [tswl_pkg::WAITER_SLOTS];
   logic [63:0]                      list_min [tswl_pkg::WAITER_SLOTS];
   int                               list_count;
   logic [63:0]                      sem_value;
   logic [tswl_pkg::TARGET_BITS-1:0] owner_target;

   sem_result_type pending_results[$];
   stim_row_type   directed_rows[$];
   bit             failed;
   bit             quiet;
   bit             long_hold_req;
   int             cycle_count;

   timeline_semaphore_waiter_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a correct run finishes far inside this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [2:0] status,
                                       logic [tswl_pkg::TARGET_BITS-1:0] tgt, logic selfw,
                                       logic last);
      sem_result_type r;
      r.kind = kind; r.status = status; r.tgt = tgt;
      r.seen = sem_value; r.selfw = selfw; r.last = last;
      pending_results.push_back(r);
   endfunction

   // Place a target after every entry whose minimum is <= m (ties keep arrival order).
   function automatic void list_insert(logic [tswl_pkg::TARGET_BITS-1:0] t, logic [63:0] m);
      int pos;
      pos = 0;
      while (pos < list_count && list_min[pos] <= m) pos++;
      for (int i = list_count; i > pos; i--) begin
         list_tgt[i] = list_tgt[i-1];
         list_min[i] = list_min[i-1];
      end
      list_tgt[pos] = t;
      list_min[pos] = m;
      list_count++;
   endfunction

   // Work out the results of one accepted transaction and advance the model.
   function automatic void predict_semaphore(logic func, logic [tswl_pkg::TARGET_BITS-1:0] t,
                                             logic [63:0] v, logic typed,
                                             logic [2:0] typed_status);
      logic [2:0] st;
      int         found;
      int         popped;
      logic       selfw;
      if (func == FUNC_WAIT) begin
         found = -1;
         if (sem_value >= v) begin
            st = tswl_pkg::ST_SATISFIED;
         end else begin
            for (int i = 0; i < list_count; i++)
               if (found < 0 && list_tgt[i] == t) found = i;
            if (found >= 0) begin
               if (v < list_min[found]) begin
                  // pull the entry out, then re-insert it at its new place
                  for (int i = found; i + 1 < list_count; i++) begin
                     list_tgt[i] = list_tgt[i+1];
                     list_min[i] = list_min[i+1];
                  end
                  list_count--;
                  list_insert(t, v);
                  st = tswl_pkg::ST_LOWERED;
               end else begin
                  st = tswl_pkg::ST_KEPT;
               end
            end else if (list_count >= tswl_pkg::WAITER_SLOTS) begin
               st = tswl_pkg::ST_FULL;
            end else begin
               list_insert(t, v);
               st = tswl_pkg::ST_QUEUED;
            end
         end
         push_result(tswl_pkg::KIND_STATUS, typed ? typed_status : st, t, 1'b0, 1'b1);
      end else begin
         sem_value = v;
         popped = 0;
         selfw = 1'b0;
         while (popped < list_count && list_min[popped] <= v) begin
            if (list_tgt[popped] == owner_target) selfw = 1'b1;
            else push_result(tswl_pkg::KIND_WAKE, tswl_pkg::ST_QUEUED, list_tgt[popped],
                             1'b0, 1'b0);
            popped++;
         end
         for (int i = 0; i + popped < list_count; i++) begin
            list_tgt[i] = list_tgt[i+popped];
            list_min[i] = list_min[i+popped];
         end
         list_count -= popped;
         push_result(tswl_pkg::KIND_DONE, tswl_pkg::ST_QUEUED, '0, selfw, 1'b1);
      end
   endfunction

   // Drive one request and hold it until the block takes it.
   task automatic send_request(logic func, logic [tswl_pkg::TARGET_BITS-1:0] t,
                               logic [63:0] v, logic typed, logic [2:0] typed_status);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, t};
      req_tuser  <= func;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      predict_semaphore(func, t, v, typed, typed_status);
   endtask

   task automatic write_owner(logic [7:0] owner);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b1;
      csr_data   <= owner;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      owner_target = owner;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain: wait for every expected result, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic void add_row(logic func, logic [tswl_pkg::TARGET_BITS-1:0] t,
                                   logic [63:0] v, logic typed, logic [2:0] st);
      stim_row_type r;
      r.func = func; r.tgt = t; r.val = v; r.typed = typed; r.status = st;
      directed_rows.push_back(r);
   endfunction

   // Receiver: random back-pressure, plus one long hold so the list path backs up.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   // Checker: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      sem_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d data %h", rsp_tuser, rsp_tdata);
            failed = 1'b1;
         end else begin
            e = pending_results.pop_front();
            if (rsp_tuser !== e.kind) begin
               $error("kind: expected %0d actual %0d", e.kind, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tdata[2:0] !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_tdata[2:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[10:3] !== e.tgt) begin
               $error("wake_target: expected %0d actual %0d", e.tgt, rsp_tdata[10:3]);
               failed = 1'b1;
            end
            if (rsp_tdata[74:11] !== e.seen) begin
               $error("seen_value: expected %h actual %h", e.seen, rsp_tdata[74:11]);
               failed = 1'b1;
            end
            if (rsp_tdata[75] !== e.selfw) begin
               $error("self_woke: expected %0d actual %0d", e.selfw, rsp_tdata[75]);
               failed = 1'b1;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %0d actual %0d", e.last, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      logic       func;
      logic [7:0] t;
      logic [63:0] v;
      int         r;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      quiet       = 1'b0;
      long_hold_req = 1'b0;
      sem_value   = '0;
      list_count  = 0;
      owner_target = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, owner target 0.
      write_owner(8'd0);
      add_row(FUNC_WAIT, 8'd5, 64'd0, 1'b1, tswl_pkg::ST_SATISFIED);   // value already met
      add_row(FUNC_WAIT, 8'd255, VALUE_MAX, 1'b1, tswl_pkg::ST_QUEUED);
      add_row(FUNC_WAIT, 8'd0, 64'd10, 1'b1, tswl_pkg::ST_QUEUED);     // owner waits
      add_row(FUNC_WAIT, 8'd7, 64'd10, 1'b1, tswl_pkg::ST_QUEUED);
      add_row(FUNC_WAIT, 8'd7, 64'd20, 1'b1, tswl_pkg::ST_KEPT);       // larger minimum ignored
      add_row(FUNC_WAIT, 8'd255, 64'd10, 1'b1, tswl_pkg::ST_LOWERED);  // moves behind equal ones
      add_row(FUNC_SIGNAL, 8'd0, 64'd10, 1'b0, tswl_pkg::ST_QUEUED);   // wakes 7, 255, flags owner
      add_row(FUNC_WAIT, 8'd9, 64'd10, 1'b1, tswl_pkg::ST_SATISFIED);  // met, though not waiting
      add_row(FUNC_SIGNAL, 8'hAA, 64'd0, 1'b0, tswl_pkg::ST_QUEUED);   // signal going down
      for (int i = 0; i < tswl_pkg::WAITER_SLOTS; i++)
         add_row(FUNC_WAIT, 8'(16 + i), 64'(100 + (i % 5)), 1'b0, tswl_pkg::ST_QUEUED);
      add_row(FUNC_WAIT, 8'd200, 64'd50, 1'b1, tswl_pkg::ST_FULL);     // table full
      add_row(FUNC_SIGNAL, 8'd0, VALUE_MAX, 1'b0, tswl_pkg::ST_QUEUED); // pops every slot
      foreach (directed_rows[i])
         send_request(directed_rows[i].func, directed_rows[i].tgt, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].status);
      drain();

      // Random part: two halves under different owners.
      for (int phase = 0; phase < 2; phase++) begin
         write_owner(phase == 0 ? 8'd255 : 8'($urandom_range(0, 19)));
         if (phase == 0) long_hold_req = 1'b1;
         // leave the semaphore low again so waits tend to queue
         send_request(FUNC_SIGNAL, 8'd0, 64'd0, 1'b0, tswl_pkg::ST_QUEUED);
         for (int n = 0; n < 40; n++) begin
            if (n % 20 == 10) quiet = ~quiet;
            r = $urandom_range(0, 99);
            func = (r < 22) ? FUNC_SIGNAL : FUNC_WAIT;
            r = $urandom_range(0, 99);
            if (r < 10)      t = owner_target;
            else if (r < 85) t = 8'($urandom_range(0, 19));
            else             t = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (func == FUNC_WAIT) begin
               if (r < 80)      v = sem_value + 64'($urandom_range(1, 60));
               else if (r < 94) v = sem_value - 64'($urandom_range(0, 5));
               else             v = {$urandom, $urandom};
            end else begin
               if (r < 70)      v = sem_value + 64'($urandom_range(0, 40));
               else if (r < 90) v = sem_value - 64'($urandom_range(1, 30));
               else if (r < 95) v = {$urandom, $urandom};
               else             v = 64'($urandom_range(0, 3));
            end
            send_request(func, t, v, 1'b0, tswl_pkg::ST_QUEUED);
         end
         quiet = 1'b0;
         send_request(FUNC_SIGNAL, 8'd0, VALUE_MAX, 1'b0, tswl_pkg::ST_QUEUED);
         drain();
      end

      if (!failed && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/tswl_pkg.sv
rtl/tswl_ram.sv
rtl/timeline_semaphore_waiter_list.sv
bench/tb_timeline_semaphore_waiter_list.sv
